// ===== rtl/hcrs_pkg.sv =====
// hcrs_pkg: shared types and constants for the hermite curve route sampler
// used by the controller, the datapath and the top level; no dependencies

package hcrs_pkg;

	// field widths
	localparam int COORD_W   = 32;
	localparam int SEG_W     = 6;
	localparam int UNIT_BITS = 30;
	localparam int MAG_W     = 33;
	localparam int OPND_W    = 34;
	localparam int WIDE_W    = 64;
	localparam int DEN_W     = 34;
	localparam int TAN_W     = 34;
	localparam int WGT_W     = 20;

	localparam logic [SEG_W-1:0] SEG_RESET = 6'd16;

	// datapath operations
	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_HALVE,
		OP_MUL_SQ,
		OP_ADD,
		OP_SQRT_GO,
		OP_SPAN,
		OP_TAN_INIT,
		OP_TAN_SHIFT,
		OP_NRM,
		OP_DIV_UNIT,
		OP_UNIT,
		OP_MUL_US,
		OP_TSCALE,
		OP_TFALL,
		OP_WGT_A,
		OP_WGT_B,
		OP_WGT_C,
		OP_MUL_PT,
		OP_DIV_PT,
		OP_PSTORE,
		OP_EMIT
	} op_t;

	// source of an emitted point
	typedef enum logic [1:0] {
		SRC_P0,
		SRC_P1,
		SRC_PT
	} src_t;

	// controller states
	typedef enum logic [4:0] {
		S_IDLE,
		S_HALVE,
		S_DSQ_MUL,
		S_DSQ_ADD,
		S_DSQRT_GO,
		S_DSQRT_WAIT,
		S_SPAN,
		S_CHECK,
		S_TINIT,
		S_TSHIFT,
		S_TFALL,
		S_TSQ_MUL,
		S_TSQ_ADD,
		S_TSQRT_GO,
		S_TSQRT_WAIT,
		S_TNRM,
		S_TDIV_GO,
		S_TDIV_WAIT,
		S_TUNIT,
		S_TMUL,
		S_TSCALE,
		S_WGT_A,
		S_WGT_B,
		S_WGT_C,
		S_PMUL,
		S_PADD,
		S_PDIV_GO,
		S_PDIV_WAIT,
		S_PSTORE,
		S_EMIT,
		S_EMIT_P0,
		S_EMIT_P1
	} state_t;

	// command from controller to datapath
	typedef struct packed {
		op_t              op;
		logic [1:0]       axis;
		logic [1:0]       term;
		logic             tsel;
		logic             first;
		logic [SEG_W-1:0] idx;
		logic             last;
		src_t             src;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic sqrt_busy;
		logic div_busy;
		logic zero_span;
		logic zero_seg;
		logic zero_dir;
		logic tan_norm;
		logic out_busy;
		logic k_last;
	} stat_t;

endpackage

// ===== rtl/hermite_curve_route_sampler.sv =====
// hermite_curve_route_sampler: top level joining controller and datapath
// depends on hcrs_pkg, hcrs_ctrl and hcrs_datapath
//
// Usage:
//  - input channel (in_valid/in_ready) takes one route: start and end points
//    and a tangent at each end, signed Q16.16; one route is worked at a time
//  - output channel (out_valid/out_ready) gives segment_count+1 curve points,
//    or two (start, end) when segment_count is 0 or both ends coincide;
//    last_point marks the final point of a route
//  - cfg channel (cfg_valid/cfg_ready/cfg_data) writes segment_count; always
//    ready, to be written only while no route is in flight
//  - the route first takes a distance square root; each tangent then takes
//    normalizing shifts, a square root and three divisions, and each point
//    then needs three divisions
//  - in_ready is high only while no route is in flight; a finished point is
//    held in the output register; the sampler goes on computing the next
//    point, but does not emit it until the held one is taken
//  - reset clears the sequencer and the output valid and sets segment_count
//    to 16

module hermite_curve_route_sampler (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [hcrs_pkg::SEG_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [hcrs_pkg::COORD_W-1:0] start_x,
	input  logic signed [hcrs_pkg::COORD_W-1:0] start_y,
	input  logic signed [hcrs_pkg::COORD_W-1:0] start_z,
	input  logic signed [hcrs_pkg::COORD_W-1:0] end_x,
	input  logic signed [hcrs_pkg::COORD_W-1:0] end_y,
	input  logic signed [hcrs_pkg::COORD_W-1:0] end_z,
	input  logic signed [hcrs_pkg::COORD_W-1:0] start_dir_x,
	input  logic signed [hcrs_pkg::COORD_W-1:0] start_dir_y,
	input  logic signed [hcrs_pkg::COORD_W-1:0] start_dir_z,
	input  logic signed [hcrs_pkg::COORD_W-1:0] end_dir_x,
	input  logic signed [hcrs_pkg::COORD_W-1:0] end_dir_y,
	input  logic signed [hcrs_pkg::COORD_W-1:0] end_dir_z,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [hcrs_pkg::COORD_W-1:0] point_x,
	output logic signed [hcrs_pkg::COORD_W-1:0] point_y,
	output logic signed [hcrs_pkg::COORD_W-1:0] point_z,
	output logic [hcrs_pkg::SEG_W-1:0]         point_index,
	output logic                               last_point
);

	hcrs_pkg::cmd_t  cmd;
	hcrs_pkg::stat_t stat;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	hcrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	hcrs_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.start_x     (start_x),
		.start_y     (start_y),
		.start_z     (start_z),
		.end_x       (end_x),
		.end_y       (end_y),
		.end_z       (end_z),
		.start_dir_x (start_dir_x),
		.start_dir_y (start_dir_y),
		.start_dir_z (start_dir_z),
		.end_dir_x   (end_dir_x),
		.end_dir_y   (end_dir_y),
		.end_dir_z   (end_dir_z),
		.cmd         (cmd),
		.stat        (stat),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.point_index (point_index),
		.last_point  (last_point)
	);

endmodule

// ===== rtl/hcrs_sqrt.sv =====
// hcrs_sqrt: iterative floor square root of a 64 bit word, two bits a cycle
// depends on hcrs_pkg

module hcrs_sqrt (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [hcrs_pkg::WIDE_W-1:0]      radicand,
	output logic                             busy,
	output logic [hcrs_pkg::WIDE_W/2-1:0]    root
);

	logic [hcrs_pkg::WIDE_W-1:0] x_q;
	logic [hcrs_pkg::WIDE_W-1:0] res_q;
	logic [hcrs_pkg::WIDE_W-1:0] bit_q;
	logic                        busy_q;
	logic [hcrs_pkg::WIDE_W-1:0] trial;

	assign trial = res_q + bit_q;
	assign busy  = busy_q;
	assign root  = res_q[hcrs_pkg::WIDE_W/2-1:0];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && bit_q[0]) begin
			busy_q <= 1'b0;
		end
	end

	// one result bit per step
	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= radicand;
			res_q <= '0;
			bit_q <= {2'b01, {(hcrs_pkg::WIDE_W-2){1'b0}}};
		end else if (busy_q) begin
			if (x_q >= trial) begin
				x_q   <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

// ===== rtl/hcrs_div.sv =====
// hcrs_div: restoring unsigned divider, 64 bit dividend, one quotient bit a cycle
// depends on hcrs_pkg

module hcrs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [hcrs_pkg::WIDE_W-1:0]   num,
	input  logic [hcrs_pkg::DEN_W-1:0]    den,
	output logic                          busy,
	output logic [hcrs_pkg::WIDE_W-1:0]   quo
);

	logic [hcrs_pkg::WIDE_W-1:0] num_q;
	logic [hcrs_pkg::WIDE_W-1:0] quo_q;
	logic [hcrs_pkg::DEN_W-1:0]  rem_q;
	logic [hcrs_pkg::DEN_W-1:0]  den_q;
	logic [5:0]                  cnt_q;
	logic                        busy_q;
	logic [hcrs_pkg::DEN_W:0]    rem_sh;
	logic [hcrs_pkg::DEN_W:0]    rem_sub;
	logic                        fits;

	assign rem_sh  = {rem_q, num_q[hcrs_pkg::WIDE_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign fits    = rem_sh >= {1'b0, den_q};
	assign busy    = busy_q;
	assign quo     = quo_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd63;
		end else if (busy_q) begin
			if (cnt_q == 6'd0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 6'd1;
		end
	end

	// shift and subtract
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			quo_q <= {quo_q[hcrs_pkg::WIDE_W-2:0], fits};
			rem_q <= fits ? rem_sub[hcrs_pkg::DEN_W-1:0] : rem_sh[hcrs_pkg::DEN_W-1:0];
		end
	end

endmodule

// ===== rtl/hcrs_datapath.sv =====
// hcrs_datapath: operand registers, shared multiplier, accumulator and output register
// depends on hcrs_pkg, hcrs_sqrt and hcrs_div

module hcrs_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [hcrs_pkg::SEG_W-1:0]         cfg_data,
	input  logic signed [hcrs_pkg::COORD_W-1:0] start_x,
	input  logic signed [hcrs_pkg::COORD_W-1:0] start_y,
	input  logic signed [hcrs_pkg::COORD_W-1:0] start_z,
	input  logic signed [hcrs_pkg::COORD_W-1:0] end_x,
	input  logic signed [hcrs_pkg::COORD_W-1:0] end_y,
	input  logic signed [hcrs_pkg::COORD_W-1:0] end_z,
	input  logic signed [hcrs_pkg::COORD_W-1:0] start_dir_x,
	input  logic signed [hcrs_pkg::COORD_W-1:0] start_dir_y,
	input  logic signed [hcrs_pkg::COORD_W-1:0] start_dir_z,
	input  logic signed [hcrs_pkg::COORD_W-1:0] end_dir_x,
	input  logic signed [hcrs_pkg::COORD_W-1:0] end_dir_y,
	input  logic signed [hcrs_pkg::COORD_W-1:0] end_dir_z,
	input  hcrs_pkg::cmd_t                     cmd,
	output hcrs_pkg::stat_t                    stat,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic signed [hcrs_pkg::COORD_W-1:0] point_x,
	output logic signed [hcrs_pkg::COORD_W-1:0] point_y,
	output logic signed [hcrs_pkg::COORD_W-1:0] point_z,
	output logic [hcrs_pkg::SEG_W-1:0]         point_index,
	output logic                               last_point
);

	localparam int CW = hcrs_pkg::COORD_W;
	localparam int MW = hcrs_pkg::MAG_W;
	localparam int OW = hcrs_pkg::OPND_W;
	localparam int WW = hcrs_pkg::WIDE_W;
	localparam int TW = hcrs_pkg::TAN_W;
	localparam int GW = hcrs_pkg::WGT_W;
	localparam int UB = hcrs_pkg::UNIT_BITS;

	// item registers
	logic signed [CW-1:0] p0_q [3];
	logic signed [CW-1:0] p1_q [3];
	logic signed [CW-1:0] d0_q [3];
	logic signed [CW-1:0] d1_q [3];
	logic signed [CW-1:0] pt_q [3];
	logic signed [CW-1:0] u_q [3];
	logic signed [TW-1:0] tan_q [2][3];
	logic [MW-1:0]        amag_q [3];
	logic signed [GW-1:0] w_q [4];
	logic signed [WW-1:0] acc_q;
	logic signed [WW-1:0] prod_s1;
	logic [CW-1:0]        hs_q;
	logic [CW-1:0]        nrm_q;
	logic                 sh_q;
	logic                 fb_q;
	logic                 zero_span_q;
	logic [5:0]           n_q;
	logic [11:0]          n2_q;
	logic [17:0]          n3_q;
	logic [11:0]          c2_q;
	logic [17:0]          c3_q;
	logic [17:0]          c2n_q;
	logic [17:0]          cn2_q;
	logic [hcrs_pkg::SEG_W-1:0] seg_q;

	// output register
	logic                 out_valid_q;
	logic signed [CW-1:0] px_q, py_q, pz_q;
	logic [hcrs_pkg::SEG_W-1:0] pidx_q;
	logic                 plast_q;

	// shared units
	logic                 sqrt_busy, div_busy, div_start;
	logic [CW-1:0]        sqrt_root;
	logic [WW-1:0]        div_num, div_quo;
	logic [hcrs_pkg::DEN_W-1:0] div_den;

	// combinational helpers
	logic signed [OW-1:0]   mul_a, mul_b;
	logic signed [2*OW-1:0] mul_full;
	logic signed [OW-1:0]   pt_val;
	logic signed [CW:0]     diff [3];
	logic signed [CW-1:0]   ends [3];
	logic signed [CW-1:0]   starts [3];
	logic signed [CW-1:0]   dsel;
	logic [WW-1:0]          acc_mag, prod_mag, rnd_sum;
	logic signed [TW-1:0]   rnd_val;
	logic signed [21:0]     e_c3, e_c2n, e_cn2, e_n3;
	logic signed [21:0]     w0, w1, w2, w3;
	logic [CW-1:0]          sat_val;
	logic                   any_big, tan_norm, zero_dir;

	assign starts[0] = start_x;
	assign starts[1] = start_y;
	assign starts[2] = start_z;
	assign ends[0]   = end_x;
	assign ends[1]   = end_y;
	assign ends[2]   = end_z;

	// distance differences straight from the ports
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			diff[j] = {ends[j][CW-1], ends[j]} - {starts[j][CW-1], starts[j]};
		end
	end

	assign any_big  = (amag_q[0][MW-1:MW-2] != 2'b00) || (amag_q[1][MW-1:MW-2] != 2'b00) ||
	                  (amag_q[2][MW-1:MW-2] != 2'b00);
	assign tan_norm = (amag_q[0][MW-1:UB] != '0) || (amag_q[1][MW-1:UB] != '0) ||
	                  (amag_q[2][MW-1:UB] != '0);
	assign zero_dir = (amag_q[0] == '0) && (amag_q[1] == '0) && (amag_q[2] == '0);
	assign dsel     = cmd.tsel ? d1_q[cmd.axis] : d0_q[cmd.axis];
	assign acc_mag  = acc_q[WW-1] ? WW'(-acc_q) : WW'(acc_q);
	assign prod_mag = prod_s1[WW-1] ? WW'(-prod_s1) : WW'(prod_s1);
	assign rnd_sum  = prod_mag + (WW'(1) << (UB - 1));
	assign rnd_val  = prod_s1[WW-1] ? -$signed(rnd_sum[WW-1:UB]) : $signed(rnd_sum[WW-1:UB]);

	// Hermite basis numerators
	assign e_c3  = $signed({4'b0, c3_q});
	assign e_c2n = $signed({4'b0, c2n_q});
	assign e_cn2 = $signed({4'b0, cn2_q});
	assign e_n3  = $signed({4'b0, n3_q});
	assign w0 = e_c3 + e_c3 - e_c2n - e_c2n - e_c2n + e_n3;
	assign w1 = e_c3 - e_c2n - e_c2n + e_cn2;
	assign w2 = e_c2n + e_c2n + e_c2n - e_c3 - e_c3;
	assign w3 = e_c3 - e_c2n;

	// term value for the point sum
	always_comb begin
		case (cmd.term)
			2'd0:    pt_val = OW'(p0_q[cmd.axis]);
			2'd1:    pt_val = tan_q[0][cmd.axis];
			2'd2:    pt_val = OW'(p1_q[cmd.axis]);
			default: pt_val = tan_q[1][cmd.axis];
		endcase
	end

	// multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			hcrs_pkg::OP_MUL_SQ: begin
				mul_a = $signed({1'b0, amag_q[cmd.axis]});
				mul_b = $signed({1'b0, amag_q[cmd.axis]});
			end
			hcrs_pkg::OP_MUL_US: begin
				mul_a = OW'(u_q[cmd.axis]);
				mul_b = $signed({2'b0, hs_q});
			end
			hcrs_pkg::OP_MUL_PT: begin
				mul_a = OW'(w_q[cmd.term]);
				mul_b = pt_val;
			end
			default: ;
		endcase
	end

	assign mul_full = mul_a * mul_b;

	// divider operands
	always_comb begin
		div_num   = '0;
		div_den   = '0;
		div_start = 1'b0;
		case (cmd.op)
			hcrs_pkg::OP_DIV_UNIT: begin
				div_start = 1'b1;
				div_num   = {2'b0, amag_q[cmd.axis][CW-1:0], {UB{1'b0}}} +
				            {{(WW-CW+1){1'b0}}, nrm_q[CW-1:1]};
				div_den   = {2'b0, nrm_q};
			end
			hcrs_pkg::OP_DIV_PT: begin
				div_start = 1'b1;
				div_num   = acc_mag + {{(WW-17){1'b0}}, n3_q[17:1]};
				div_den   = {16'b0, n3_q};
			end
			default: ;
		endcase
	end

	// saturation of the signed quotient
	always_comb begin
		if (!acc_q[WW-1]) begin
			sat_val = (div_quo > WW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_quo[CW-1:0];
		end else begin
			sat_val = (div_quo > WW'(32'h8000_0000)) ? 32'h8000_0000 :
			          32'(32'd0 - div_quo[CW-1:0]);
		end
	end

	hcrs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == hcrs_pkg::OP_SQRT_GO),
		.radicand ($unsigned(acc_q)),
		.busy     (sqrt_busy),
		.root     (sqrt_root)
	);

	hcrs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	// segment count register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q       <= hcrs_pkg::SEG_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				seg_q <= cfg_data;
			end
			if (cmd.op == hcrs_pkg::OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		prod_s1 <= mul_full[WW-1:0];
		case (cmd.op)
			hcrs_pkg::OP_LOAD: begin
				p0_q[0] <= start_x;     p0_q[1] <= start_y;     p0_q[2] <= start_z;
				p1_q[0] <= end_x;       p1_q[1] <= end_y;       p1_q[2] <= end_z;
				d0_q[0] <= start_dir_x; d0_q[1] <= start_dir_y; d0_q[2] <= start_dir_z;
				d1_q[0] <= end_dir_x;   d1_q[1] <= end_dir_y;   d1_q[2] <= end_dir_z;
				for (int j = 0; j < 3; j++) begin
					amag_q[j] <= diff[j][CW] ? MW'(-diff[j]) : MW'(diff[j]);
				end
				n_q  <= seg_q;
				fb_q <= end_x >= start_x;
				sh_q <= 1'b0;
			end
			hcrs_pkg::OP_HALVE: begin
				if (any_big) begin
					for (int j = 0; j < 3; j++) begin
						amag_q[j] <= amag_q[j] >> 1;
					end
					sh_q <= 1'b1;
				end
				n2_q <= {6'b0, n_q} * {6'b0, n_q};
			end
			hcrs_pkg::OP_ADD: begin
				acc_q <= cmd.first ? prod_s1 : acc_q + prod_s1;
			end
			hcrs_pkg::OP_SPAN: begin
				hs_q        <= sh_q ? sqrt_root : (sqrt_root >> 1);
				zero_span_q <= sqrt_root == '0;
				n3_q        <= {6'b0, n2_q} * {12'b0, n_q};
			end
			hcrs_pkg::OP_TAN_INIT: begin
				for (int j = 0; j < 3; j++) begin
					if (cmd.tsel) begin
						amag_q[j] <= d1_q[j][CW-1] ? MW'(-{d1_q[j][CW-1], d1_q[j]})
						                          : MW'({1'b0, d1_q[j]});
					end else begin
						amag_q[j] <= d0_q[j][CW-1] ? MW'(-{d0_q[j][CW-1], d0_q[j]})
						                          : MW'({1'b0, d0_q[j]});
					end
				end
			end
			hcrs_pkg::OP_TAN_SHIFT: begin
				for (int j = 0; j < 3; j++) begin
					amag_q[j] <= amag_q[j] << 1;
				end
			end
			hcrs_pkg::OP_NRM: begin
				nrm_q <= sqrt_root;
			end
			hcrs_pkg::OP_UNIT: begin
				u_q[cmd.axis] <= dsel[CW-1] ? -$signed(div_quo[CW-1:0])
				                            : $signed(div_quo[CW-1:0]);
			end
			hcrs_pkg::OP_TSCALE: begin
				tan_q[cmd.tsel][cmd.axis] <= rnd_val;
			end
			hcrs_pkg::OP_TFALL: begin
				tan_q[cmd.tsel][0] <= fb_q ? $signed({2'b0, hs_q}) : -$signed({2'b0, hs_q});
				tan_q[cmd.tsel][1] <= '0;
				tan_q[cmd.tsel][2] <= '0;
			end
			hcrs_pkg::OP_WGT_A: begin
				c2_q  <= {6'b0, cmd.idx} * {6'b0, cmd.idx};
				cn2_q <= {12'b0, cmd.idx} * {6'b0, n2_q};
			end
			hcrs_pkg::OP_WGT_B: begin
				c3_q  <= {6'b0, c2_q} * {12'b0, cmd.idx};
				c2n_q <= {6'b0, c2_q} * {12'b0, n_q};
			end
			hcrs_pkg::OP_WGT_C: begin
				w_q[0] <= w0[GW-1:0];
				w_q[1] <= w1[GW-1:0];
				w_q[2] <= w2[GW-1:0];
				w_q[3] <= w3[GW-1:0];
			end
			hcrs_pkg::OP_PSTORE: begin
				pt_q[cmd.axis] <= sat_val;
			end
			hcrs_pkg::OP_EMIT: begin
				case (cmd.src)
					hcrs_pkg::SRC_P0: begin
						px_q <= p0_q[0]; py_q <= p0_q[1]; pz_q <= p0_q[2];
					end
					hcrs_pkg::SRC_P1: begin
						px_q <= p1_q[0]; py_q <= p1_q[1]; pz_q <= p1_q[2];
					end
					default: begin
						px_q <= pt_q[0]; py_q <= pt_q[1]; pz_q <= pt_q[2];
					end
				endcase
				pidx_q  <= cmd.idx;
				plast_q <= cmd.last;
			end
			default: ;
		endcase
	end

	// status back to the controller
	assign stat.sqrt_busy = sqrt_busy;
	assign stat.div_busy  = div_busy;
	assign stat.zero_span = zero_span_q;
	assign stat.zero_seg  = n_q == '0;
	assign stat.zero_dir  = zero_dir;
	assign stat.tan_norm  = tan_norm;
	assign stat.out_busy  = out_valid_q && !out_ready;
	assign stat.k_last    = cmd.idx == n_q;

	assign out_valid   = out_valid_q;
	assign point_x     = px_q;
	assign point_y     = py_q;
	assign point_z     = pz_q;
	assign point_index = pidx_q;
	assign last_point  = plast_q;

endmodule

// ===== rtl/hcrs_ctrl.sv =====
// hcrs_ctrl: sequencing state machine for the hermite curve route sampler
// depends on hcrs_pkg; drives the datapath through hcrs_pkg::cmd_t

module hcrs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  hcrs_pkg::stat_t stat,
	output hcrs_pkg::cmd_t  cmd
);

	hcrs_pkg::state_t state_q, state_d;
	logic [1:0]       axis_q;
	logic [1:0]       term_q;
	logic             tsel_q;
	logic [hcrs_pkg::SEG_W-1:0] k_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hcrs_pkg::S_IDLE:       if (in_valid) state_d = hcrs_pkg::S_HALVE;
			hcrs_pkg::S_HALVE:      state_d = hcrs_pkg::S_DSQ_MUL;
			hcrs_pkg::S_DSQ_MUL:    state_d = hcrs_pkg::S_DSQ_ADD;
			hcrs_pkg::S_DSQ_ADD:    state_d = (axis_q == 2'd2) ? hcrs_pkg::S_DSQRT_GO
			                                                   : hcrs_pkg::S_DSQ_MUL;
			hcrs_pkg::S_DSQRT_GO:   state_d = hcrs_pkg::S_DSQRT_WAIT;
			hcrs_pkg::S_DSQRT_WAIT: if (!stat.sqrt_busy) state_d = hcrs_pkg::S_SPAN;
			hcrs_pkg::S_SPAN:       state_d = hcrs_pkg::S_CHECK;
			hcrs_pkg::S_CHECK:      state_d = (stat.zero_span || stat.zero_seg) ?
			                                  hcrs_pkg::S_EMIT_P0 : hcrs_pkg::S_TINIT;
			hcrs_pkg::S_TINIT:      state_d = hcrs_pkg::S_TSHIFT;
			hcrs_pkg::S_TSHIFT: begin
				if (stat.zero_dir) begin
					state_d = hcrs_pkg::S_TFALL;
				end else if (stat.tan_norm) begin
					state_d = hcrs_pkg::S_TSQ_MUL;
				end
			end
			hcrs_pkg::S_TFALL:      state_d = tsel_q ? hcrs_pkg::S_WGT_A : hcrs_pkg::S_TINIT;
			hcrs_pkg::S_TSQ_MUL:    state_d = hcrs_pkg::S_TSQ_ADD;
			hcrs_pkg::S_TSQ_ADD:    state_d = (axis_q == 2'd2) ? hcrs_pkg::S_TSQRT_GO
			                                                   : hcrs_pkg::S_TSQ_MUL;
			hcrs_pkg::S_TSQRT_GO:   state_d = hcrs_pkg::S_TSQRT_WAIT;
			hcrs_pkg::S_TSQRT_WAIT: if (!stat.sqrt_busy) state_d = hcrs_pkg::S_TNRM;
			hcrs_pkg::S_TNRM:       state_d = hcrs_pkg::S_TDIV_GO;
			hcrs_pkg::S_TDIV_GO:    state_d = hcrs_pkg::S_TDIV_WAIT;
			hcrs_pkg::S_TDIV_WAIT:  if (!stat.div_busy) state_d = hcrs_pkg::S_TUNIT;
			hcrs_pkg::S_TUNIT:      state_d = hcrs_pkg::S_TMUL;
			hcrs_pkg::S_TMUL:       state_d = hcrs_pkg::S_TSCALE;
			hcrs_pkg::S_TSCALE: begin
				if (axis_q != 2'd2) begin
					state_d = hcrs_pkg::S_TDIV_GO;
				end else begin
					state_d = tsel_q ? hcrs_pkg::S_WGT_A : hcrs_pkg::S_TINIT;
				end
			end
			hcrs_pkg::S_WGT_A:      state_d = hcrs_pkg::S_WGT_B;
			hcrs_pkg::S_WGT_B:      state_d = hcrs_pkg::S_WGT_C;
			hcrs_pkg::S_WGT_C:      state_d = hcrs_pkg::S_PMUL;
			hcrs_pkg::S_PMUL:       state_d = hcrs_pkg::S_PADD;
			hcrs_pkg::S_PADD:       state_d = (term_q == 2'd3) ? hcrs_pkg::S_PDIV_GO
			                                                   : hcrs_pkg::S_PMUL;
			hcrs_pkg::S_PDIV_GO:    state_d = hcrs_pkg::S_PDIV_WAIT;
			hcrs_pkg::S_PDIV_WAIT:  if (!stat.div_busy) state_d = hcrs_pkg::S_PSTORE;
			hcrs_pkg::S_PSTORE:     state_d = (axis_q == 2'd2) ? hcrs_pkg::S_EMIT
			                                                   : hcrs_pkg::S_PMUL;
			hcrs_pkg::S_EMIT: begin
				if (!stat.out_busy) begin
					state_d = stat.k_last ? hcrs_pkg::S_IDLE : hcrs_pkg::S_WGT_A;
				end
			end
			hcrs_pkg::S_EMIT_P0:    if (!stat.out_busy) state_d = hcrs_pkg::S_EMIT_P1;
			hcrs_pkg::S_EMIT_P1:    if (!stat.out_busy) state_d = hcrs_pkg::S_IDLE;
			default:                state_d = hcrs_pkg::S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd       = '0;
		cmd.op    = hcrs_pkg::OP_NOP;
		cmd.src   = hcrs_pkg::SRC_PT;
		cmd.axis  = axis_q;
		cmd.term  = term_q;
		cmd.tsel  = tsel_q;
		cmd.idx   = k_q;
		cmd.first = 1'b0;
		cmd.last  = 1'b0;
		in_ready  = 1'b0;
		case (state_q)
			hcrs_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = hcrs_pkg::OP_LOAD;
			end
			hcrs_pkg::S_HALVE:    cmd.op = hcrs_pkg::OP_HALVE;
			hcrs_pkg::S_DSQ_MUL,
			hcrs_pkg::S_TSQ_MUL:  cmd.op = hcrs_pkg::OP_MUL_SQ;
			hcrs_pkg::S_DSQ_ADD,
			hcrs_pkg::S_TSQ_ADD: begin
				cmd.op    = hcrs_pkg::OP_ADD;
				cmd.first = axis_q == 2'd0;
			end
			hcrs_pkg::S_DSQRT_GO,
			hcrs_pkg::S_TSQRT_GO: cmd.op = hcrs_pkg::OP_SQRT_GO;
			hcrs_pkg::S_SPAN:     cmd.op = hcrs_pkg::OP_SPAN;
			hcrs_pkg::S_TINIT:    cmd.op = hcrs_pkg::OP_TAN_INIT;
			hcrs_pkg::S_TSHIFT: begin
				if (!stat.zero_dir && !stat.tan_norm) cmd.op = hcrs_pkg::OP_TAN_SHIFT;
			end
			hcrs_pkg::S_TFALL:    cmd.op = hcrs_pkg::OP_TFALL;
			hcrs_pkg::S_TNRM:     cmd.op = hcrs_pkg::OP_NRM;
			hcrs_pkg::S_TDIV_GO:  cmd.op = hcrs_pkg::OP_DIV_UNIT;
			hcrs_pkg::S_TUNIT:    cmd.op = hcrs_pkg::OP_UNIT;
			hcrs_pkg::S_TMUL:     cmd.op = hcrs_pkg::OP_MUL_US;
			hcrs_pkg::S_TSCALE:   cmd.op = hcrs_pkg::OP_TSCALE;
			hcrs_pkg::S_WGT_A:    cmd.op = hcrs_pkg::OP_WGT_A;
			hcrs_pkg::S_WGT_B:    cmd.op = hcrs_pkg::OP_WGT_B;
			hcrs_pkg::S_WGT_C:    cmd.op = hcrs_pkg::OP_WGT_C;
			hcrs_pkg::S_PMUL:     cmd.op = hcrs_pkg::OP_MUL_PT;
			hcrs_pkg::S_PADD: begin
				cmd.op    = hcrs_pkg::OP_ADD;
				cmd.first = term_q == 2'd0;
			end
			hcrs_pkg::S_PDIV_GO:  cmd.op = hcrs_pkg::OP_DIV_PT;
			hcrs_pkg::S_PSTORE:   cmd.op = hcrs_pkg::OP_PSTORE;
			hcrs_pkg::S_EMIT: begin
				cmd.last = stat.k_last;
				if (!stat.out_busy) cmd.op = hcrs_pkg::OP_EMIT;
			end
			hcrs_pkg::S_EMIT_P0: begin
				cmd.src = hcrs_pkg::SRC_P0;
				cmd.idx = '0;
				if (!stat.out_busy) cmd.op = hcrs_pkg::OP_EMIT;
			end
			hcrs_pkg::S_EMIT_P1: begin
				cmd.src  = hcrs_pkg::SRC_P1;
				cmd.idx  = hcrs_pkg::SEG_W'(1);
				cmd.last = 1'b1;
				if (!stat.out_busy) cmd.op = hcrs_pkg::OP_EMIT;
			end
			default: ;
		endcase
	end

	// state and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hcrs_pkg::S_IDLE;
			axis_q  <= '0;
			term_q  <= '0;
			tsel_q  <= 1'b0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				hcrs_pkg::S_IDLE: begin
					axis_q <= '0;
					term_q <= '0;
					tsel_q <= 1'b0;
					k_q    <= '0;
				end
				hcrs_pkg::S_DSQ_ADD,
				hcrs_pkg::S_TSQ_ADD,
				hcrs_pkg::S_PSTORE: axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
				hcrs_pkg::S_TSCALE: begin
					axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
					if (axis_q == 2'd2) tsel_q <= 1'b1;
				end
				hcrs_pkg::S_TFALL:  tsel_q <= 1'b1;
				hcrs_pkg::S_PADD:   term_q <= term_q + 2'd1;
				hcrs_pkg::S_EMIT: begin
					if (!stat.out_busy) k_q <= k_q + hcrs_pkg::SEG_W'(1);
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/hcrs_checker.sv =====
// hcrs_checker: port level assertions for the hermite curve route sampler
// depends on hcrs_pkg; bound to hermite_curve_route_sampler at the end of this file

module hcrs_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [hcrs_pkg::COORD_W-1:0] point_x,
	input logic [hcrs_pkg::SEG_W-1:0]   point_index,
	input logic                         last_point
);

	// a stalled result transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(point_x) &&
		$stable(point_index) && $stable(last_point))
		else $error("stalled result changed");

	// the first point of a route is never its last
	a_first_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (point_index == '0) |-> !last_point)
		else $error("point zero flagged last");

	// a route in flight blocks the next input transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	// a waiting non-final point means the route is still in flight
	a_route_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_point |-> !in_ready)
		else $error("input opened before the last point");

endmodule

bind hermite_curve_route_sampler hcrs_checker u_hcrs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.point_x     (point_x),
	.point_index (point_index),
	.last_point  (last_point)
);
